// ===== src/upsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsc_pkg
// Shared types and constants of the integer pixel replicating upscaler.
// ----------------------------------------------------------------------------
package upsc_pkg;

    localparam int MAX_IN_WIDTH = 512;
    localparam int MAX_SCALE    = 16;
    localparam int QUEUE_DEPTH  = 2;   // power of two

    localparam int COLOR_W  = 8;
    localparam int PIXEL_W  = 3 * COLOR_W;
    localparam int SCALE_W  = 5;
    localparam int WIDTH_W  = 10;
    localparam int KIND_W   = 2;
    localparam int PAD_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = WIDTH_W;

    localparam int PIX_IDX_W = $clog2(MAX_IN_WIDTH);
    localparam int REP_W     = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH = CFG_IDX_W'(1);

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_PAD    = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef enum logic [0:0] {
        BK_EXEC = 1'b0,
        BK_READ = 1'b1
    } t_back_state;

    typedef struct packed {
        t_op                op;
        logic [PIXEL_W-1:0] pixel;   // {red, green, blue}
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [WIDTH_W-1:0] in_width;
    } t_cfg;

endpackage

// ===== src/upsc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsc_in_if
// Input channel: opcode and pushed pixel bytes with valid / ready.
// ----------------------------------------------------------------------------
interface upsc_in_if;
    import upsc_pkg::*;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [COLOR_W-1:0] in_blue;
    logic [COLOR_W-1:0] in_green;
    logic [COLOR_W-1:0] in_red;

    modport source (output valid, opcode, in_blue, in_green, in_red, input ready);
    modport sink   (input valid, opcode, in_blue, in_green, in_red, output ready);
endinterface

// ===== src/upsc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsc_out_if
// Result channel: kind, pixel bytes and row markers with valid / ready.
// ----------------------------------------------------------------------------
interface upsc_out_if;
    import upsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [COLOR_W-1:0] out_blue;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_red;
    logic               row_end;
    logic               group_end;

    modport source (output valid, kind, out_blue, out_green, out_red, row_end, group_end,
                    input ready);
    modport sink   (input valid, kind, out_blue, out_green, out_red, row_end, group_end,
                    output ready);
endinterface

// ===== src/upsc_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsc_cfg_if
// Configuration write channel: register index and data with valid / ready.
// ----------------------------------------------------------------------------
interface upsc_cfg_if;
    import upsc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/upsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsc_front
// Accepts input beats, tags them as push or pull and queues them for the
// back end.
// ----------------------------------------------------------------------------
module upsc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    upsc_in_if.sink          i_px,
    input  logic             i_pop,
    output upsc_pkg::t_q_head o_head
);
    import upsc_pkg::*;

    t_item             r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              push;
    logic              pop;
    t_item             item;

    assign i_px.ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push       = i_px.valid && i_px.ready;
    assign pop        = i_pop && (r_count != '0);

    assign item.op    = t_op'(i_px.opcode);
    assign item.pixel = {i_px.in_red, i_px.in_green, i_px.in_blue};

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_queue[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= item;
        end
    end

endmodule

// ===== src/upsc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsc_back
// Executes queued items: fills the row store, replays it with horizontal
// and vertical repeats plus row padding, and holds the result register.
// ----------------------------------------------------------------------------
module upsc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  upsc_pkg::t_cfg    i_cfg,
    input  upsc_pkg::t_q_head i_head,
    output logic              o_pop,
    upsc_out_if.source        o_px
);
    import upsc_pkg::*;

    logic [PIXEL_W-1:0]   mem [MAX_IN_WIDTH];
    logic [PIXEL_W-1:0]   r_rd_data;

    t_back_state          r_state, n_state;
    logic [WIDTH_W-1:0]   r_fill, n_fill;
    logic                 r_replay, n_replay;
    logic [PIX_IDX_W-1:0] r_read_pixel, n_read_pixel;
    logic [REP_W-1:0]     r_rep_across, n_rep_across;
    logic [REP_W-1:0]     r_rep_down, n_rep_down;
    logic [PAD_W-1:0]     r_pad_left, n_pad_left;
    logic                 r_pend_rend, n_pend_rend;
    logic                 r_pend_gend, n_pend_gend;

    logic                 r_out_valid, n_out_valid;
    t_kind                r_out_kind, n_out_kind;
    logic [PIXEL_W-1:0]   r_out_pixel, n_out_pixel;
    logic                 r_out_rend, n_out_rend;
    logic                 r_out_gend, n_out_gend;

    logic [SCALE_W-1:0]   s;
    logic [WIDTH_W-1:0]   w;
    logic [3:0]           pad_prod;
    logic [PAD_W-1:0]     pad;
    logic [WIDTH_W-1:0]   fill_inc;
    logic                 last_pixel;
    logic                 last_across;
    logic                 last_down;
    logic                 slot_free;
    logic                 wr_en;
    logic                 rd_en;
    logic                 do_finish;
    t_kind                res_kind;
    logic                 res_rend;
    logic                 res_gend;

    always_comb begin
        if (i_cfg.scale == '0) begin
            s = SCALE_W'(1);
        end else if (i_cfg.scale > SCALE_W'(MAX_SCALE)) begin
            s = SCALE_W'(MAX_SCALE);
        end else begin
            s = i_cfg.scale;
        end
        if (i_cfg.in_width == '0) begin
            w = WIDTH_W'(1);
        end else if (i_cfg.in_width > WIDTH_W'(MAX_IN_WIDTH)) begin
            w = WIDTH_W'(MAX_IN_WIDTH);
        end else begin
            w = i_cfg.in_width;
        end
    end

    // padding bytes per output row equal (w * s) mod 4
    assign pad_prod    = w[1:0] * s[1:0];
    assign pad         = pad_prod[PAD_W-1:0];
    assign fill_inc    = r_fill + 1'b1;
    assign last_pixel  = (WIDTH_W'(r_read_pixel) + 1'b1) >= w;
    assign last_across = (SCALE_W'(r_rep_across) + 1'b1) >= s;
    assign last_down   = (SCALE_W'(r_rep_down) + 1'b1) >= s;
    assign slot_free   = !r_out_valid || o_px.ready;

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_replay     = r_replay;
        n_read_pixel = r_read_pixel;
        n_rep_across = r_rep_across;
        n_rep_down   = r_rep_down;
        n_pad_left   = r_pad_left;
        n_pend_rend  = r_pend_rend;
        n_pend_gend  = r_pend_gend;
        n_out_valid  = r_out_valid && !o_px.ready;
        n_out_kind   = r_out_kind;
        n_out_pixel  = r_out_pixel;
        n_out_rend   = r_out_rend;
        n_out_gend   = r_out_gend;
        o_pop        = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        do_finish    = 1'b0;
        res_kind     = KIND_NONE;
        res_rend     = 1'b0;
        res_gend     = 1'b0;

        case (r_state)
            BK_EXEC: begin
                if (i_head.valid && slot_free) begin
                    o_pop = 1'b1;
                    if (i_head.item.op == OP_PUSH) begin
                        if (r_replay) begin
                            res_kind = KIND_REJECT;
                        end else begin
                            wr_en  = 1'b1;
                            n_fill = fill_inc;
                            if (fill_inc >= w || fill_inc == '0) begin
                                n_replay     = 1'b1;
                                n_read_pixel = '0;
                                n_rep_across = '0;
                                n_rep_down   = '0;
                                n_pad_left   = '0;
                            end
                        end
                    end else if (r_replay) begin
                        if (r_pad_left != '0) begin
                            res_kind   = KIND_PAD;
                            n_pad_left = r_pad_left - 1'b1;
                            if (r_pad_left == PAD_W'(1)) begin
                                res_rend  = 1'b1;
                                do_finish = 1'b1;
                            end
                        end else begin
                            rd_en = 1'b1;
                            if (last_pixel && last_across) begin
                                n_read_pixel = '0;
                                n_rep_across = '0;
                                if (pad != '0) begin
                                    n_pad_left = pad;
                                end else begin
                                    res_rend  = 1'b1;
                                    do_finish = 1'b1;
                                end
                            end else if (last_across) begin
                                n_rep_across = '0;
                                n_read_pixel = r_read_pixel + 1'b1;
                            end else begin
                                n_rep_across = r_rep_across + 1'b1;
                            end
                        end
                    end
                end
            end
            BK_READ: begin
                if (slot_free) begin
                    n_state     = BK_EXEC;
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_PIXEL;
                    n_out_pixel = r_rd_data;
                    n_out_rend  = r_pend_rend;
                    n_out_gend  = r_pend_gend;
                end
            end
            default: begin
                n_state = BK_EXEC;
            end
        endcase

        // end of one output row
        if (do_finish) begin
            if (last_down) begin
                n_rep_down   = '0;
                n_replay     = 1'b0;
                n_fill       = '0;
                n_read_pixel = '0;
                n_rep_across = '0;
                n_pad_left   = '0;
            end else begin
                n_rep_down = r_rep_down + 1'b1;
            end
        end
        res_gend = do_finish && last_down;

        if (rd_en) begin
            n_state     = BK_READ;
            n_pend_rend = res_rend;
            n_pend_gend = res_gend;
        end else if (o_pop) begin
            n_out_valid = 1'b1;
            n_out_kind  = res_kind;
            n_out_pixel = '0;
            n_out_rend  = res_rend;
            n_out_gend  = res_gend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_EXEC;
            r_fill       <= '0;
            r_replay     <= 1'b0;
            r_read_pixel <= '0;
            r_rep_across <= '0;
            r_rep_down   <= '0;
            r_pad_left   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fill       <= n_fill;
            r_replay     <= n_replay;
            r_read_pixel <= n_read_pixel;
            r_rep_across <= n_rep_across;
            r_rep_down   <= n_rep_down;
            r_pad_left   <= n_pad_left;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_rend <= n_pend_rend;
        r_pend_gend <= n_pend_gend;
        r_out_kind  <= n_out_kind;
        r_out_pixel <= n_out_pixel;
        r_out_rend  <= n_out_rend;
        r_out_gend  <= n_out_gend;
    end

    // row store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_fill[PIX_IDX_W-1:0]] <= i_head.item.pixel;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_read_pixel];
        end
    end

    assign o_px.valid     = r_out_valid;
    assign o_px.kind      = r_out_kind;
    assign o_px.out_blue  = r_out_pixel[COLOR_W-1:0];
    assign o_px.out_green = r_out_pixel[2*COLOR_W-1:COLOR_W];
    assign o_px.out_red   = r_out_pixel[3*COLOR_W-1:2*COLOR_W];
    assign o_px.row_end   = r_out_rend;
    assign o_px.group_end = r_out_gend;

endmodule

// ===== src/integer_pixel_replicating_upscaler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_pixel_replicating_upscaler_core
// Nearest-neighbor integer upscaler for rows of 24-bit pixels.
//
// Channels: i_px carries one item per beat (opcode 0 pushes a pixel into
// the row store, opcode 1 pulls the next output item); o_px returns exactly
// one result beat per input beat, in order. i_cfg writes scale (index 0)
// and in_width (index 1), is always ready and is used while idle; the user
// must keep to that, the block does not enforce it. A beat passes the queue,
// then the result register; a pixel pull also passes the registered row
// store read port, and no new item is taken until that pixel is registered.
// Pushes, padding and idle pulls go one beat per cycle while o_px is ready.
// A two-entry queue between front end and back end keeps i_px ready while
// a result waits on o_px; when the receiver stalls, the result register
// holds and the queue fills, then i_px.ready drops.
// Reset clears counters, the fill state and the result valid, and sets
// scale and in_width to 1; the row store is not cleared.
// ----------------------------------------------------------------------------
module integer_pixel_replicating_upscaler_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    upsc_in_if.sink    i_px,
    upsc_out_if.source o_px,
    upsc_cfg_if.sink   i_cfg
);
    import upsc_pkg::*;

    logic [SCALE_W-1:0] r_scale;
    logic [WIDTH_W-1:0] r_in_width;
    t_cfg               cfg;
    t_q_head            head;
    logic               pop;

    assign i_cfg.ready  = 1'b1;
    assign cfg.scale    = r_scale;
    assign cfg.in_width = r_in_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= SCALE_W'(1);
            r_in_width <= WIDTH_W'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == REG_SCALE) begin
                r_scale <= i_cfg.data[SCALE_W-1:0];
            end
            if (i_cfg.index == REG_IN_WIDTH) begin
                r_in_width <= i_cfg.data[WIDTH_W-1:0];
            end
        end
    end

    upsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (i_px),
        .i_pop   (pop),
        .o_head  (head)
    );

    upsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_head  (head),
        .o_pop   (pop),
        .o_px    (o_px)
    );

endmodule

// ===== src/upsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsc_checker
// Port-level checks on the result channel of the upscaler core.
// ----------------------------------------------------------------------------
module upsc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_ready,
    input logic [upsc_pkg::KIND_W-1:0] i_kind,
    input logic [upsc_pkg::COLOR_W-1:0] i_blue,
    input logic [upsc_pkg::COLOR_W-1:0] i_green,
    input logic [upsc_pkg::COLOR_W-1:0] i_red,
    input logic                        i_row_end,
    input logic                        i_group_end
);
    import upsc_pkg::*;

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_blue)
            && $stable(i_green) && $stable(i_red) && $stable(i_row_end)
            && $stable(i_group_end))
        else $error("stalled result beat changed");

    a_row_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_row_end |-> i_kind == KIND_PIXEL || i_kind == KIND_PAD)
        else $error("row end on a beat that is no pixel or padding");

    a_group_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_group_end |-> i_row_end)
        else $error("group end without row end");

    a_zero_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != KIND_PIXEL |-> i_blue == '0 && i_green == '0 && i_red == '0)
        else $error("nonzero pixel bytes on a non-pixel beat");

endmodule

bind integer_pixel_replicating_upscaler_core upsc_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_px.valid),
    .i_ready     (o_px.ready),
    .i_kind      (o_px.kind),
    .i_blue      (o_px.out_blue),
    .i_green     (o_px.out_green),
    .i_red       (o_px.out_red),
    .i_row_end   (o_px.row_end),
    .i_group_end (o_px.group_end)
);
